### design/fcte_pkg.sv
// Shared types, codes and the CRC update for the framed CRC transfer engine.
package fcte_pkg;

    localparam int PAYLOAD_DEPTH = 1024;
    localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);
    localparam int PLEN_W        = PAYLOAD_AW + 1;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] PAUSE_TICKS   = 8'd100;
    localparam logic [7:0] SHORT_TIMEOUT = 8'd5;
    localparam logic [7:0] LEN_TIMEOUT   = 8'd10;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;

    // Input function codes.
    localparam logic [2:0] FUNC_LOAD  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_SLOT  = 3'd2;
    localparam logic [2:0] FUNC_RX    = 3'd3;
    localparam logic [2:0] FUNC_TICK  = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_TX      = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_ABORT   = 3'd2;
    localparam logic [2:0] KIND_SUCCESS = 3'd3;
    localparam logic [2:0] KIND_GAVE_UP = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_RETRIES = 2'd0;
    localparam logic [1:0] REG_RX_CAPACITY = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SEND,
        PH_ACK,
        PH_IDX,
        PH_LH,
        PH_LL,
        PH_DATA,
        PH_CH,
        PH_CL,
        PH_PAUSE
    } phase_t;

    // Reflected CRC-CCITT update by one byte.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        begin
            d = b ^ crc[7:0];
            d = d ^ {d[3:0], 4'b0};
            crc_feed = {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b0};
        end
    endfunction

endpackage

### design/fcte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/framed_crc_transfer_engine.sv
// Top level of the framed CRC transfer engine: frame sender, reply parser, retry control.
//
// Usage: every input transfer on the s_ channel carries a function code in s_tuser
// (load payload byte, start, transmit slot, received byte, millisecond tick) and a
// byte in s_tdata. Payload bytes are loaded while idle, then start begins an attempt.
// Each transmit slot yields one frame byte; received bytes are parsed as the reply.
// Results leave on the m_ channel: m_tuser is the kind, m_tdata the byte and count,
// and m_tlast marks success or giving up.
// Each accepted transfer is handled in the cycle it is accepted; its result, if any,
// is valid on the m_ channel the next cycle. One transfer is taken every unstalled cycle.
// The payload is held in a 1024-entry RAM; its read address follows the next send
// position, so the byte is ready at the slot and slots can come back to back.
// While m_tvalid is high and m_tready low, s_tready drops; nothing is lost.
// Reset (aresetn low at a clock edge) returns the engine to idle with an empty
// payload, index zero and default registers; the RAM needs no clearing.
// Write registers with cfg_wr_en/cfg_addr/cfg_wdata while idle; only the user ensures it.
module framed_crc_transfer_engine
    import fcte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] value, [23:8] count
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [7:0]  max_retries_reg;
    logic [15:0] rx_capacity_reg;
    logic [7:0]  ack_timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [PLEN_W-1:0] spos_reg, spos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  attempt_reg, attempt_next;
    logic [7:0]  timer_reg, timer_next;
    logic [15:0] rlen_reg, rlen_next;
    logic [15:0] rpos_reg, rpos_next;
    logic [7:0]  crchi_reg, crchi_next;

    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [7:0]  out_value_reg;
    logic [15:0] out_count_reg;
    logic        out_last_reg;

    logic        acc;
    logic [2:0]  func;
    logic [7:0]  din;
    logic [7:0]  ram_rdata;
    logic        ram_we;
    logic [PLEN_W+1:0] len4;
    logic [PLEN_W+1:0] pos_ext;
    logic [7:0]  slot_byte;
    logic        slot_feed;
    logic        slot_done;
    logic        limit_phase;
    logic [7:0]  limit;
    logic [7:0]  timer_inc;
    logic        timeout;
    logic [7:0]  attempt_inc;
    logic        final_attempt;
    logic        do_abort;
    logic [15:0] rpos_inc;
    logic [15:0] rlen_full;
    logic        res_valid;
    logic [2:0]  res_kind;
    logic [7:0]  res_value;
    logic [15:0] res_count;
    logic        res_last;

    assign acc      = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign func     = s_tuser;
    assign din      = s_tdata;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The read address tracks the next send position, so the byte is ready at the slot.
    fcte_ram #(
        .WIDTH(8),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_payload (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (plen_reg[PAYLOAD_AW-1:0]),
        .wdata (din),
        .raddr (PAYLOAD_AW'(spos_next - PLEN_W'(4))),
        .rdata (ram_rdata)
    );

    // Shared decode of the current transfer.
    always_comb begin
        len4      = (PLEN_W+2)'(plen_reg) + (PLEN_W+2)'(4);
        pos_ext   = (PLEN_W+2)'(spos_reg);
        slot_feed = pos_ext < len4;
        slot_done = pos_ext >= len4 + (PLEN_W+2)'(1);
        if (spos_reg == PLEN_W'(0)) begin
            slot_byte = SYNC_BYTE;
        end else if (spos_reg == PLEN_W'(1)) begin
            slot_byte = idx_reg;
        end else if (spos_reg == PLEN_W'(2)) begin
            slot_byte = 8'(plen_reg >> 8);
        end else if (spos_reg == PLEN_W'(3)) begin
            slot_byte = plen_reg[7:0];
        end else if (slot_feed) begin
            slot_byte = ram_rdata;
        end else if (pos_ext == len4) begin
            slot_byte = crc_reg[15:8];
        end else begin
            slot_byte = crc_reg[7:0];
        end

        limit_phase = 1'b1;
        case (phase_reg)
            PH_ACK:                          limit = ack_timeout_reg;
            PH_LH, PH_LL:                    limit = LEN_TIMEOUT;
            PH_IDX, PH_DATA, PH_CH, PH_CL:   limit = SHORT_TIMEOUT;
            PH_PAUSE:                        limit = PAUSE_TICKS;
            default: begin
                limit       = 8'd0;
                limit_phase = 1'b0;
            end
        endcase
        timer_inc = (timer_reg == 8'hFF) ? timer_reg : timer_reg + 8'd1;
        timeout   = limit_phase && (timer_inc >= limit);

        attempt_inc   = attempt_reg + 8'd1;
        final_attempt = attempt_inc >= max_retries_reg;
        rpos_inc      = rpos_reg + 16'd1;
        rlen_full     = {rlen_reg[15:8], din};

        do_abort = 1'b0;
        if (func == FUNC_RX) begin
            if ((phase_reg == PH_ACK && din != SYNC_BYTE)
                || (phase_reg == PH_IDX && din != idx_reg)
                || (phase_reg == PH_CL && {crchi_reg, din} != crc_reg)) begin
                do_abort = 1'b1;
            end
        end else if (func == FUNC_TICK) begin
            do_abort = timeout && (phase_reg != PH_PAUSE);
        end
    end

    // Next-state logic.
    always_comb begin
        phase_next   = phase_reg;
        plen_next    = plen_reg;
        spos_next    = spos_reg;
        crc_next     = crc_reg;
        idx_next     = idx_reg;
        attempt_next = attempt_reg;
        timer_next   = timer_reg;
        rlen_next    = rlen_reg;
        rpos_next    = rpos_reg;
        crchi_next   = crchi_reg;
        ram_we       = 1'b0;
        if (acc) begin
            case (func)
                FUNC_LOAD: begin
                    if (phase_reg == PH_IDLE && plen_reg < PLEN_W'(PAYLOAD_DEPTH)) begin
                        ram_we    = 1'b1;
                        plen_next = plen_reg + PLEN_W'(1);
                    end
                end
                FUNC_START: begin
                    if (phase_reg == PH_IDLE) begin
                        attempt_next = 8'd0;
                        timer_next   = 8'd0;
                        if (max_retries_reg == 8'd0) begin
                            plen_next = '0;
                        end else begin
                            phase_next = PH_SEND;
                            spos_next  = '0;
                            crc_next   = CRC_INIT;
                        end
                    end
                end
                FUNC_SLOT: begin
                    if (phase_reg == PH_SEND) begin
                        if (slot_feed) begin
                            crc_next = crc_feed(crc_reg, slot_byte);
                        end
                        if (slot_done) begin
                            phase_next = PH_ACK;
                            timer_next = 8'd0;
                        end else begin
                            spos_next = spos_reg + PLEN_W'(1);
                        end
                    end
                end
                FUNC_RX: begin
                    case (phase_reg)
                        PH_ACK: begin
                            crc_next   = crc_feed(CRC_INIT, din);
                            phase_next = PH_IDX;
                            timer_next = 8'd0;
                        end
                        PH_IDX: begin
                            crc_next   = crc_feed(crc_reg, din);
                            phase_next = PH_LH;
                            timer_next = 8'd0;
                        end
                        PH_LH: begin
                            rlen_next  = {din, 8'h00};
                            crc_next   = crc_feed(crc_reg, din);
                            phase_next = PH_LL;
                            timer_next = 8'd0;
                        end
                        PH_LL: begin
                            rlen_next  = rlen_full;
                            crc_next   = crc_feed(crc_reg, din);
                            rpos_next  = 16'd0;
                            phase_next = (rlen_full == 16'd0) ? PH_CH : PH_DATA;
                            timer_next = 8'd0;
                        end
                        PH_DATA: begin
                            crc_next   = crc_feed(crc_reg, din);
                            rpos_next  = rpos_inc;
                            phase_next = (rpos_inc == rlen_reg) ? PH_CH : PH_DATA;
                            timer_next = 8'd0;
                        end
                        PH_CH: begin
                            crchi_next = din;
                            phase_next = PH_CL;
                            timer_next = 8'd0;
                        end
                        PH_CL: begin
                            idx_next   = idx_reg + 8'd1;
                            timer_next = 8'd0;
                            phase_next = PH_IDLE;
                            plen_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
                FUNC_TICK: begin
                    if (limit_phase) begin
                        timer_next = timer_inc;
                        if (timeout && phase_reg == PH_PAUSE) begin
                            timer_next = 8'd0;
                            phase_next = PH_SEND;
                            spos_next  = '0;
                            crc_next   = CRC_INIT;
                        end
                    end
                end
                default: begin
                end
            endcase

            // An abort overrides whatever the byte or tick would have done.
            if (do_abort) begin
                attempt_next = attempt_inc;
                timer_next   = 8'd0;
                crc_next     = crc_reg;
                idx_next     = idx_reg;
                plen_next    = plen_reg;
                if (final_attempt) begin
                    phase_next = PH_IDLE;
                    plen_next  = '0;
                end else begin
                    phase_next = PH_PAUSE;
                end
            end
        end
    end

    // Result of the current transfer.
    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_TX;
        res_value = 8'd0;
        res_count = 16'd0;
        res_last  = 1'b0;
        if (do_abort) begin
            res_valid = 1'b1;
            res_kind  = final_attempt ? KIND_GAVE_UP : KIND_ABORT;
            res_last  = final_attempt;
        end else begin
            case (func)
                FUNC_START: begin
                    if (phase_reg == PH_IDLE && max_retries_reg == 8'd0) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_GAVE_UP;
                        res_last  = 1'b1;
                    end
                end
                FUNC_SLOT: begin
                    if (phase_reg == PH_SEND) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_TX;
                        res_value = slot_byte;
                    end
                end
                FUNC_RX: begin
                    if (phase_reg == PH_DATA && rpos_reg < rx_capacity_reg) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_DATA;
                        res_value = din;
                    end else if (phase_reg == PH_CL) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_SUCCESS;
                        res_count = (rlen_reg > rx_capacity_reg) ? rx_capacity_reg : rlen_reg;
                        res_last  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= 8'd50;
            rx_capacity_reg <= 16'hFFFF;
            ack_timeout_reg <= 8'd100;
            phase_reg       <= PH_IDLE;
            plen_reg        <= '0;
            spos_reg        <= '0;
            crc_reg         <= CRC_INIT;
            idx_reg         <= 8'd0;
            attempt_reg     <= 8'd0;
            timer_reg       <= 8'd0;
            rlen_reg        <= 16'd0;
            rpos_reg        <= 16'd0;
            crchi_reg       <= 8'd0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MAX_RETRIES: max_retries_reg <= cfg_wdata[7:0];
                    REG_RX_CAPACITY: rx_capacity_reg <= cfg_wdata;
                    REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            phase_reg   <= phase_next;
            plen_reg    <= plen_next;
            spos_reg    <= spos_next;
            crc_reg     <= crc_next;
            idx_reg     <= idx_next;
            attempt_reg <= attempt_next;
            timer_reg   <= timer_next;
            rlen_reg    <= rlen_next;
            rpos_reg    <= rpos_next;
            crchi_reg   <= crchi_next;
            if (acc && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && res_valid) begin
            out_kind_reg  <= res_kind;
            out_value_reg <= res_value;
            out_count_reg <= res_count;
            out_last_reg  <= res_last;
        end
    end

endmodule

### tb/testbench.sv
// Self-checking testbench for the framed CRC transfer engine.
module testbench;
    import fcte_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [15:0] count;
        logic        last;
    } engine_result_t;

    framed_crc_transfer_engine i_dut (.*);

    always #1 aclk = ~aclk;

    // Predicted engine state.
    logic [7:0]  mdl_max_retries, mdl_ack_timeout;
    logic [15:0] mdl_rx_capacity;
    logic [7:0]  mdl_store [PAYLOAD_DEPTH];
    int unsigned mdl_plen, mdl_send_pos;
    phase_t      mdl_phase;
    logic [15:0] mdl_crc, mdl_reply_len, mdl_reply_pos;
    logic [7:0]  mdl_index, mdl_attempts, mdl_timer, mdl_crc_high;

    engine_result_t expected_results[$];
    int errors = 0;
    int checked = 0;
    int successes = 0;
    int idle_count = 0;
    bit stall_enable = 1'b1;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] d;
        d = b ^ crc[7:0];
        d = d ^ (d << 4);
        return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b0};
    endfunction

    function automatic void push_result(input logic [2:0] k, input logic [7:0] v,
                                        input logic [15:0] c, input logic l);
        engine_result_t r;
        r.kind = k; r.value = v; r.count = c; r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void end_transfer();
        mdl_phase = PH_IDLE;
        mdl_plen = 0;
    endfunction

    function automatic void abort_predict();
        mdl_attempts = mdl_attempts + 8'd1;
        mdl_timer = 0;
        if (mdl_attempts >= mdl_max_retries) begin
            end_transfer();
            push_result(KIND_GAVE_UP, 8'd0, 16'd0, 1'b1);
        end else begin
            mdl_phase = PH_PAUSE;
            push_result(KIND_ABORT, 8'd0, 16'd0, 1'b0);
        end
    endfunction

    function automatic void await_phase(input phase_t p);
        mdl_phase = p;
        mdl_timer = 0;
    endfunction

    function automatic void predict_engine(input logic [2:0] func, input logic [7:0] b);
        logic [7:0]  tx;
        logic [15:0] pos, got;
        int unsigned lim;
        case (func)
            FUNC_LOAD: begin
                if (mdl_phase == PH_IDLE && mdl_plen < PAYLOAD_DEPTH) begin
                    mdl_store[mdl_plen] = b;
                    mdl_plen++;
                end
            end
            FUNC_START: begin
                if (mdl_phase == PH_IDLE) begin
                    mdl_attempts = 0;
                    mdl_timer = 0;
                    if (mdl_max_retries == 0) begin
                        end_transfer();
                        push_result(KIND_GAVE_UP, 8'd0, 16'd0, 1'b1);
                    end else begin
                        mdl_phase = PH_SEND; mdl_send_pos = 0; mdl_crc = CRC_INIT;
                    end
                end
            end
            FUNC_SLOT: begin
                if (mdl_phase == PH_SEND) begin
                    if (mdl_send_pos == 0) tx = SYNC_BYTE;
                    else if (mdl_send_pos == 1) tx = mdl_index;
                    else if (mdl_send_pos == 2) tx = 8'(mdl_plen >> 8);
                    else if (mdl_send_pos == 3) tx = 8'(mdl_plen);
                    else if (mdl_send_pos < 4 + mdl_plen) tx = mdl_store[mdl_send_pos - 4];
                    else if (mdl_send_pos == 4 + mdl_plen) tx = mdl_crc[15:8];
                    else tx = mdl_crc[7:0];
                    if (mdl_send_pos < 4 + mdl_plen) mdl_crc = crc_step(mdl_crc, tx);
                    if (mdl_send_pos >= 5 + mdl_plen) await_phase(PH_ACK);
                    else mdl_send_pos++;
                    push_result(KIND_TX, tx, 16'd0, 1'b0);
                end
            end
            FUNC_RX: begin
                case (mdl_phase)
                    PH_ACK: begin
                        if (b != SYNC_BYTE) abort_predict();
                        else begin
                            mdl_crc = crc_step(CRC_INIT, b);
                            await_phase(PH_IDX);
                        end
                    end
                    PH_IDX: begin
                        if (b != mdl_index) abort_predict();
                        else begin
                            mdl_crc = crc_step(mdl_crc, b);
                            await_phase(PH_LH);
                        end
                    end
                    PH_LH: begin
                        mdl_reply_len = {b, 8'd0};
                        mdl_crc = crc_step(mdl_crc, b);
                        await_phase(PH_LL);
                    end
                    PH_LL: begin
                        mdl_reply_len = mdl_reply_len | b;
                        mdl_crc = crc_step(mdl_crc, b);
                        mdl_reply_pos = 0;
                        await_phase(mdl_reply_len == 0 ? PH_CH : PH_DATA);
                    end
                    PH_DATA: begin
                        pos = mdl_reply_pos;
                        mdl_crc = crc_step(mdl_crc, b);
                        mdl_reply_pos = pos + 16'd1;
                        await_phase(mdl_reply_pos == mdl_reply_len ? PH_CH : PH_DATA);
                        if (pos < mdl_rx_capacity) push_result(KIND_DATA, b, 16'd0, 1'b0);
                    end
                    PH_CH: begin
                        mdl_crc_high = b;
                        await_phase(PH_CL);
                    end
                    PH_CL: begin
                        got = {mdl_crc_high, b};
                        if (got != mdl_crc) abort_predict();
                        else begin
                            mdl_index = mdl_index + 8'd1;
                            mdl_timer = 0;
                            end_transfer();
                            push_result(KIND_SUCCESS, 8'd0,
                                mdl_reply_len > mdl_rx_capacity ? mdl_rx_capacity
                                                                : mdl_reply_len, 1'b1);
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_TICK: begin
                case (mdl_phase)
                    PH_ACK: lim = mdl_ack_timeout;
                    PH_LH, PH_LL: lim = LEN_TIMEOUT;
                    PH_IDX, PH_DATA, PH_CH, PH_CL: lim = SHORT_TIMEOUT;
                    PH_PAUSE: lim = PAUSE_TICKS;
                    default: lim = 0;
                endcase
                if (mdl_phase != PH_IDLE && mdl_phase != PH_SEND) begin
                    if (mdl_timer < 8'd255) mdl_timer = mdl_timer + 8'd1;
                    if (mdl_timer >= lim) begin
                        if (mdl_phase == PH_PAUSE) begin
                            mdl_timer = 0;
                            mdl_phase = PH_SEND; mdl_send_pos = 0; mdl_crc = CRC_INIT;
                        end else begin
                            abort_predict();
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Result checker and receiver stalls.
    always @(posedge aclk) begin
        engine_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            idle_count <= 0;
            checked <= checked + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%0h count=%0d last=%0b",
                         $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
                errors <= errors + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tuser !== exp_r.kind || m_tdata[7:0] !== exp_r.value ||
                    m_tdata[23:8] !== exp_r.count || m_tlast !== exp_r.last) begin
                    $display("%0t: mismatch expected kind=%0d value=%0h count=%0d last=%0b",
                             $time, exp_r.kind, exp_r.value, exp_r.count, exp_r.last);
                    $display("%0t:          actual   kind=%0d value=%0h count=%0d last=%0b",
                             $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
                    errors <= errors + 1;
                end
                if (exp_r.kind == KIND_SUCCESS) successes <= successes + 1;
            end
        end else if (!(s_tvalid && s_tready)) begin
            idle_count <= idle_count + 1;
        end else begin
            idle_count <= 0;
        end
        m_tready <= stall_enable ? ($urandom_range(0, 99) < 75 || gap_length() == 0) : 1'b1;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (idle_count > 20000) begin
            $display("framed_crc_transfer_engine verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] func, input logic [7:0] b);
        int g;
        g = stall_enable ? gap_length() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_engine(func, b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] addr, input logic [15:0] v);
        cfg_wr_en <= 1'b1; cfg_addr <= addr; cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_MAX_RETRIES: mdl_max_retries = v[7:0];
            REG_RX_CAPACITY: mdl_rx_capacity = v;
            default:         mdl_ack_timeout = v[7:0];
        endcase
    endtask

    // Sends the whole frame, waiting one slot per byte.
    task automatic send_frame();
        while (mdl_phase == PH_SEND) send_item(FUNC_SLOT, 8'($urandom));
    endtask

    // Builds and sends a reply for the current index, optionally corrupted.
    task automatic send_reply(input int unsigned len, input bit corrupt_crc);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = crc_step(CRC_INIT, SYNC_BYTE);
        send_item(FUNC_RX, SYNC_BYTE);
        crc = crc_step(crc, mdl_index);
        send_item(FUNC_RX, mdl_index);
        crc = crc_step(crc, 8'(len >> 8));
        send_item(FUNC_RX, 8'(len >> 8));
        crc = crc_step(crc, 8'(len));
        send_item(FUNC_RX, 8'(len));
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if ($urandom_range(0, 19) == 0) send_item(FUNC_TICK, 8'd0);
            crc = crc_step(crc, b);
            send_item(FUNC_RX, b);
        end
        if (corrupt_crc) crc[$urandom_range(0, 15)] ^= 1'b1;
        send_item(FUNC_RX, crc[15:8]);
        send_item(FUNC_RX, crc[7:0]);
    endtask

    task automatic load_payload(input int unsigned n, input bit extreme);
        for (int i = 0; i < n; i++)
            send_item(FUNC_LOAD, extreme ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
    endtask

    task automatic tick_until_resend();
        while (mdl_phase == PH_PAUSE || mdl_phase == PH_ACK) send_item(FUNC_TICK, 8'd0);
    endtask

    task automatic test_directed();
        // Ignored functions while idle and mid-attempt, including undefined codes.
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_RX, 8'hFF);
        send_item(FUNC_SLOT, 8'h00);
        send_item(3'd5, 8'hAA);
        send_item(3'd7, 8'h55);
        load_payload(3, 1'b1);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_LOAD, 8'h12);
        send_frame();
        send_item(FUNC_SLOT, 8'h00);
        send_reply(0, 1'b0);
        drain();
        // Zero retries gives up at once.
        write_register(REG_MAX_RETRIES, 16'd0);
        send_item(FUNC_START, 8'h00);
        drain();
    endtask

    task automatic test_timeouts();
        write_register(REG_MAX_RETRIES, 16'd3);
        write_register(REG_ACK_TIMEOUT, 16'd1);
        load_payload(2, 1'b0);
        send_item(FUNC_START, 8'h00);
        send_frame();
        send_item(FUNC_TICK, 8'h00);          // ack timeout, first attempt aborted
        tick_until_resend();                   // pause, then second attempt
        send_frame();
        send_item(FUNC_RX, 8'hFF);
        for (int i = 0; i < 5; i++) send_item(FUNC_TICK, 8'h00);   // index timeout
        tick_until_resend();
        send_frame();
        send_item(FUNC_RX, 8'h00);            // bad start byte on final attempt
        drain();
        write_register(REG_ACK_TIMEOUT, 16'd255);
        write_register(REG_MAX_RETRIES, 16'd255);
    endtask

    task automatic test_capacity();
        write_register(REG_RX_CAPACITY, 16'd0);
        load_payload(1, 1'b0);
        send_item(FUNC_START, 8'h00);
        send_frame();
        send_reply(4, 1'b0);
        drain();
        write_register(REG_RX_CAPACITY, 16'd3);
        send_item(FUNC_START, 8'h00);
        send_frame();
        send_reply(6, 1'b1);                   // bad CRC aborts
        tick_until_resend();
        send_frame();
        send_reply(6, 1'b0);
        drain();
        write_register(REG_RX_CAPACITY, 16'hFFFF);
    endtask

    task automatic test_full_store();
        load_payload(PAYLOAD_DEPTH + 2, 1'b0);
        send_item(FUNC_START, 8'h00);
        stall_enable = 1'b0;
        send_frame();
        stall_enable = 1'b1;
        send_reply(2, 1'b0);
        drain();
    endtask

    task automatic test_random(input int unsigned n_items);
        int unsigned sent;
        int r;
        sent = 0;
        while (sent < n_items) begin
            if (mdl_phase == PH_IDLE) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    drain();
                    write_register(REG_RX_CAPACITY, 16'($urandom_range(0, 8)));
                    write_register(REG_MAX_RETRIES, 16'($urandom_range(1, 3)));
                    write_register(REG_ACK_TIMEOUT, 16'($urandom_range(1, 6)));
                end
                load_payload($urandom_range(0, 8), 1'b0);
                send_item(FUNC_START, 8'($urandom));
                sent += 2;
            end else if (mdl_phase == PH_SEND) begin
                send_frame();
                sent += 6;
            end else if (mdl_phase == PH_ACK) begin
                r = $urandom_range(0, 9);
                if (r < 7) send_reply($urandom_range(0, 8), r == 6);
                else send_item(3'($urandom_range(0, 7)), 8'($urandom));
                sent += 6;
            end else begin
                send_item($urandom_range(0, 1) ? FUNC_TICK : 3'($urandom_range(0, 7)),
                          8'($urandom));
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        mdl_max_retries = 8'd50; mdl_rx_capacity = 16'hFFFF; mdl_ack_timeout = 8'd100;
        mdl_plen = 0; mdl_phase = PH_IDLE; mdl_send_pos = 0; mdl_crc = CRC_INIT;
        mdl_index = 0; mdl_attempts = 0; mdl_timer = 0; mdl_reply_len = 0;
        mdl_reply_pos = 0; mdl_crc_high = 0;
        test_directed();
        test_timeouts();
        test_capacity();
        test_full_store();
        test_random(400);
        repeat (10) @(posedge aclk);
        $display("Covered idle noise, timeouts, retries, give-up, capacity limits,");
        $display("a full payload store and random frames: %0d results, %0d successes.",
                 checked, successes);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("framed_crc_transfer_engine verification clean");
        end else begin
            $display("framed_crc_transfer_engine verification failed");
        end
        $finish;
    end

endmodule
